FILE: sv/pts_pkg.sv
`default_nettype none
package pts_pkg;
  localparam int unsigned TimerSlots = 16;
  localparam int unsigned SlotW = $clog2(TimerSlots);
  localparam logic [15:0] IdLimit = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_ADD = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    EV_ADD = 2'd0,
    EV_REMOVE = 2'd1,
    EV_FIRED = 2'd2,
    EV_IDLE = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FIRE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_step;
    logic commit_add;
    logic commit_remove;
    logic fire;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found_free;
    logic id_hit;
    logic best_found;
    logic [4:0] fired;
    req_e req;
    logic out_busy;
  } status_t;
endpackage
`default_nettype wire

FILE: sv/pts_ctrl.sv
`default_nettype none
module pts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pts_pkg::status_t sts_i,
  output pts_pkg::cmd_t    cmd_o
);
  import pts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = sts_i.out_busy;
        if (in_valid_i && !sts_i.out_busy) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_clear = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.req == REQ_NONE) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.scan_done) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        case (sts_i.req)
          REQ_ADD: begin
            if (!sts_i.out_busy) begin
              cmd_o.commit_add = 1'b1;
              state_d = ST_IDLE;
            end
          end
          REQ_REMOVE: begin
            if (!sts_i.out_busy) begin
              cmd_o.commit_remove = 1'b1;
              state_d = ST_IDLE;
            end
          end
          default: begin
            if (!sts_i.out_busy) begin
              if (sts_i.best_found) begin
                // another timer is due: the held firing is not the last one
                cmd_o.fire = 1'b1;
                cmd_o.emit = (sts_i.fired != 5'd0);
                state_d = ST_FIRE;
              end else begin
                cmd_o.emit = 1'b1;
                state_d = ST_IDLE;
              end
            end
          end
        endcase
      end
      ST_FIRE: begin
        if (sts_i.fired[4]) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.scan_clear = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: sv/pts_dp.sv
`default_nettype none
module pts_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       req_type_i,
  input  logic [15:0]      delay_i,
  input  logic [15:0]      period_i,
  input  logic [15:0]      repeat_count_i,
  input  logic [15:0]      target_id_i,
  input  pts_pkg::cmd_t    cmd_i,
  output pts_pkg::status_t sts_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       event_kind_o,
  output logic [15:0]      timer_id_o,
  output logic             success_o,
  output logic             last_o
);
  import pts_pkg::*;

  logic [TimerSlots-1:0] valid_q, done_q;
  logic [31:0] dl_q [TimerSlots];
  logic [15:0] per_q [TimerSlots];
  logic [15:0] rem_q [TimerSlots];
  logic [15:0] sid_q [TimerSlots];
  logic [31:0] now_q;
  logic [15:0] last_id_q;
  req_e req_q;
  logic [15:0] delay_q, period_q, count_q, target_q;
  logic [SlotW:0] idx_q;
  logic [SlotW-1:0] free_q, hit_q, best_q;
  logic free_ok_q, hit_ok_q, best_ok_q;
  logic [4:0] fired_q;
  logic [15:0] pend_q;
  logic ov_q;
  logic [1:0] kind_q;
  logic [15:0] oid_q;
  logic ok_q, last_q;

  logic [SlotW-1:0] i;
  logic [15:0] new_id, key_id;
  logic cand, better;
  logic [15:0] rem_dec;

  assign i = idx_q[SlotW-1:0];
  assign new_id = (last_id_q == IdLimit) ? 16'd1 : last_id_q + 16'd1;
  assign key_id = (req_q == REQ_ADD) ? new_id : target_q;
  assign cand = valid_q[i] && !done_q[i] && (dl_q[i] <= now_q);
  assign better = !best_ok_q || (dl_q[i] < dl_q[best_q]) ||
                  ((dl_q[i] == dl_q[best_q]) && (sid_q[i] < sid_q[best_q]));
  assign rem_dec = (rem_q[best_q] == 16'd0) ? 16'd0 : rem_q[best_q] - 16'd1;

  assign sts_o.scan_done = (idx_q == (SlotW + 1)'(TimerSlots - 1));
  assign sts_o.found_free = free_ok_q;
  assign sts_o.id_hit = hit_ok_q;
  assign sts_o.best_found = best_ok_q;
  assign sts_o.fired = fired_q;
  assign sts_o.req = req_q;
  assign sts_o.out_busy = ov_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      now_q <= '0;
      last_id_q <= '0;
      ov_q <= 1'b0;
      req_q <= REQ_NONE;
      idx_q <= '0;
      free_ok_q <= 1'b0;
      hit_ok_q <= 1'b0;
      best_ok_q <= 1'b0;
      fired_q <= '0;
      done_q <= '0;
    end else begin
      if (cmd_i.commit_add || cmd_i.commit_remove || cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
      if (cmd_i.load) begin
        req_q <= req_e'(req_type_i);
        delay_q <= delay_i;
        period_q <= period_i;
        count_q <= repeat_count_i;
        target_q <= target_id_i;
        fired_q <= '0;
        done_q <= '0;
        if (req_e'(req_type_i) == REQ_TICK) now_q <= now_q + 32'd1;
      end
      if (cmd_i.scan_clear) begin
        idx_q <= '0;
        free_ok_q <= 1'b0;
        hit_ok_q <= 1'b0;
        best_ok_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + (SlotW + 1)'(1);
        if (!valid_q[i] && !free_ok_q) begin
          free_ok_q <= 1'b1;
          free_q <= i;
        end
        if (valid_q[i] && sid_q[i] == key_id && !hit_ok_q) begin
          hit_ok_q <= 1'b1;
          hit_q <= i;
        end
        if (cand && better) begin
          best_ok_q <= 1'b1;
          best_q <= i;
        end
      end
      if (cmd_i.commit_add) begin
        last_id_q <= new_id;
        kind_q <= EV_ADD;
        last_q <= 1'b1;
        if (free_ok_q && !hit_ok_q) begin
          valid_q[free_q] <= 1'b1;
          dl_q[free_q] <= now_q + {16'd0, delay_q};
          per_q[free_q] <= (period_q == 16'd0) ? 16'd1 : period_q;
          rem_q[free_q] <= count_q;
          sid_q[free_q] <= new_id;
          oid_q <= new_id;
          ok_q <= 1'b1;
        end else begin
          oid_q <= '0;
          ok_q <= 1'b0;
        end
      end
      if (cmd_i.commit_remove) begin
        kind_q <= EV_REMOVE;
        oid_q <= target_q;
        ok_q <= hit_ok_q;
        last_q <= 1'b1;
        if (hit_ok_q) valid_q[hit_q] <= 1'b0;
      end
      // a held firing goes out once a scan shows if it is last, or after the 16th
      if (cmd_i.emit) begin
        if (fired_q == 5'd0) begin
          kind_q <= EV_IDLE;
          oid_q <= '0;
          ok_q <= 1'b0;
          last_q <= 1'b1;
        end else begin
          kind_q <= EV_FIRED;
          oid_q <= pend_q;
          ok_q <= 1'b1;
          last_q <= !best_ok_q || fired_q[4];
        end
      end
      if (cmd_i.fire) begin
        pend_q <= sid_q[best_q];
        fired_q <= fired_q + 5'd1;
        done_q[best_q] <= 1'b1;
        rem_q[best_q] <= rem_dec;
        if (rem_dec == 16'd0) valid_q[best_q] <= 1'b0;
        else dl_q[best_q] <= now_q + {16'd0, per_q[best_q]};
      end
    end
  end

  assign out_valid_o = ov_q;
  assign event_kind_o = kind_q;
  assign timer_id_o = oid_q;
  assign success_o = ok_q;
  assign last_o = last_q;
endmodule
`default_nettype wire

FILE: sv/periodic_timer_scheduler.sv
// Periodic timer scheduler, 16 timer slots.
// Input channel: in_valid_i / in_stall_o with req_type_i and the add/remove
// fields. Output channel: out_valid_o / out_stall_i with event_kind_o,
// timer_id_o, success_o, last_o. A transfer happens when valid is high and
// stall is low.
// Add and remove: one scan over all slots, then the ack. Tick: a slot scan,
// then another after each firing but the 16th, to pick the earliest deadline
// (lowest id on ties).
// A tick that fires timers gives one result per firing, last_o marks the
// final one; a tick with nothing due gives a single idle result.
// Reset clears time, the id counter and all slot valid bits.
// While the receiver stalls the result is held and the next firing waits; no
// new input is taken until the pending result has been transferred.
`default_nettype none
module periodic_timer_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] delay_i,
  input  logic [15:0] period_i,
  input  logic [15:0] repeat_count_i,
  input  logic [15:0] target_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [15:0] timer_id_o,
  output logic        success_o,
  output logic        last_o
);
  import pts_pkg::*;

  cmd_t cmd;
  status_t sts;

  pts_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sts_i(sts), .cmd_o(cmd)
  );

  pts_dp u_dp (
    .clk_i, .rst_ni, .req_type_i, .delay_i, .period_i, .repeat_count_i,
    .target_id_i, .cmd_i(cmd), .sts_o(sts), .out_valid_o, .out_stall_i,
    .event_kind_o, .timer_id_o, .success_o, .last_o
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.commit_add, cmd.commit_remove, cmd.emit}))
    else $error("multiple result commands");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(timer_id_o))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !in_stall_o)
    else $error("load without transfer");
`endif
endmodule
`default_nettype wire

FILE: test/tb_periodic_timer_scheduler.sv
`default_nettype none
module tb_periodic_timer_scheduler;
  import pts_pkg::*;

  localparam int unsigned NSlots = 16;
  localparam int unsigned MaxFire = 16;
  localparam int unsigned CycleLimit = 500000;

  typedef struct packed {
    event_e    kind;
    logic [15:0] id;
    logic        ok;
    logic        fin;
  } evt_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = REQ_TICK;
  logic [15:0] delay_i = '0;
  logic [15:0] period_i = '0;
  logic [15:0] repeat_count_i = '0;
  logic [15:0] target_id_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [1:0]  event_kind_o;
  logic [15:0] timer_id_o;
  logic        success_o;
  logic        last_o;

  periodic_timer_scheduler i_dut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [31:0] now_q;
  logic [15:0] id_gen_q;
  logic        t_valid [NSlots];
  logic [31:0] t_deadline [NSlots];
  logic [15:0] t_period [NSlots];
  logic [15:0] t_left [NSlots];
  logic [15:0] t_id [NSlots];

  evt_t pending_events[$];
  int   errors = 0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_off = 1'b0;

  function automatic int slot_of(logic [15:0] id);
    for (int i = 0; i < NSlots; i++)
      if (t_valid[i] && t_id[i] == id) return i;
    return -1;
  endfunction

  task automatic predict(req_e req, logic [15:0] dly, logic [15:0] per,
                         logic [15:0] rep, logic [15:0] tgt);
    int   free_slot;
    int   s;
    int   best;
    int   n;
    logic due [NSlots];
    evt_t last_evt;
    if (req == REQ_ADD) begin
      id_gen_q = (id_gen_q == IdLimit) ? 16'd1 : id_gen_q + 16'd1;
      free_slot = -1;
      for (int i = NSlots - 1; i >= 0; i--)
        if (!t_valid[i]) free_slot = i;
      if (free_slot < 0 || slot_of(id_gen_q) >= 0) begin
        pending_events.push_back('{EV_ADD, 16'd0, 1'b0, 1'b1});
      end else begin
        t_valid[free_slot] = 1'b1;
        t_deadline[free_slot] = now_q + 32'(dly);
        t_period[free_slot] = (per == 0) ? 16'd1 : per;
        t_left[free_slot] = rep;
        t_id[free_slot] = id_gen_q;
        pending_events.push_back('{EV_ADD, id_gen_q, 1'b1, 1'b1});
      end
    end else if (req == REQ_REMOVE) begin
      s = slot_of(tgt);
      if (s >= 0) t_valid[s] = 1'b0;
      pending_events.push_back('{EV_REMOVE, tgt, s >= 0, 1'b1});
    end else if (req == REQ_TICK) begin
      now_q = now_q + 32'd1;
      for (int i = 0; i < NSlots; i++) due[i] = t_valid[i] && t_deadline[i] <= now_q;
      n = 0;
      while (n < MaxFire) begin
        best = -1;
        for (int i = 0; i < NSlots; i++)
          if (due[i] && (best < 0 || t_deadline[i] < t_deadline[best] ||
              (t_deadline[i] == t_deadline[best] && t_id[i] < t_id[best])))
            best = i;
        if (best < 0) break;
        due[best] = 1'b0;
        pending_events.push_back('{EV_FIRED, t_id[best], 1'b1, 1'b0});
        n++;
        if (t_left[best] > 0) t_left[best] = t_left[best] - 16'd1;
        if (t_left[best] == 0) t_valid[best] = 1'b0;
        else t_deadline[best] = now_q + 32'(t_period[best]);
      end
      if (n == 0) begin
        pending_events.push_back('{EV_IDLE, 16'd0, 1'b0, 1'b1});
      end else begin
        last_evt = pending_events.pop_back();
        last_evt.fin = 1'b1;
        pending_events.push_back(last_evt);
      end
    end
  endtask

  task automatic send_req(req_e req, logic [15:0] dly = 0, logic [15:0] per = 0,
                          logic [15:0] rep = 0, logic [15:0] tgt = 0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    delay_i <= dly;
    period_i <= per;
    repeat_count_i <= rep;
    target_id_i <= tgt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict(req, dly, per, rep, tgt);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    evt_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result kind=%0d id=%0d ok=%0d last=%0d", $time,
                 event_kind_o, timer_id_o, success_o, last_o);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind_o !== want.kind || timer_id_o !== want.id ||
            success_o !== want.ok || last_o !== want.fin) begin
          $display("%0t: mismatch expected kind=%0d id=%0d ok=%0d last=%0d,",
                   $time, want.kind, want.id, want.ok, want.fin,
                   " actual kind=%0d id=%0d ok=%0d last=%0d",
                   event_kind_o, timer_id_o, success_o, last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL periodic_timer_scheduler");
      $finish;
    end
  end

  task automatic drain();
    stop_sending();
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic test_add_remove();
    send_req(REQ_ADD, 16'd0, 16'd0, 16'd0);
    send_req(REQ_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_req(REQ_REMOVE, 0, 0, 0, 16'd2);
    send_req(REQ_REMOVE, 0, 0, 0, 16'd2);
    send_req(REQ_REMOVE, 0, 0, 0, 16'd0);
    send_req(REQ_REMOVE, 0, 0, 0, 16'hFFFF);
    send_req(REQ_NONE);
    send_req(REQ_TICK);
    send_req(REQ_TICK);
  endtask

  task automatic test_repeat_and_ties();
    send_req(REQ_ADD, 16'd2, 16'd0, 16'd3);
    send_req(REQ_ADD, 16'd2, 16'd1, 16'd1);
    send_req(REQ_ADD, 16'd1, 16'd2, 16'd2);
    repeat (6) send_req(REQ_TICK);
  endtask

  task automatic test_full_table();
    repeat (NSlots + 2) send_req(REQ_ADD, 16'd3, 16'd1, 16'd2);
    repeat (4) send_req(REQ_TICK);
  endtask

  task automatic test_random(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 35) send_req(REQ_TICK);
      else if (r < 70)
        send_req(REQ_ADD, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(6)),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3)),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4)));
      else if (r < 95)
        send_req(REQ_REMOVE, 16'($urandom), 16'($urandom), 16'($urandom),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'(id_gen_q - $urandom_range(8)));
      else send_req(REQ_NONE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        repeat (6) send_req(REQ_ADD, 16'd1, 16'd1, 16'd2);
        repeat (4) send_req(REQ_TICK);
        stop_sending();
      end
    join
  endtask

  initial begin
    now_q = '0;
    id_gen_q = '0;
    for (int i = 0; i < NSlots; i++) t_valid[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_add_remove();
    test_repeat_and_ties();
    test_full_table();
    test_backpressure();
    send_idle_pct = 38;
    recv_idle_pct = 59;
    test_random(40);
    send_idle_pct = 59;
    recv_idle_pct = 38;
    test_random(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(40);
    drain();
    if (errors == 0) $display("PASS periodic_timer_scheduler");
    else $display("FAIL periodic_timer_scheduler");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
sv/pts_pkg.sv
sv/pts_ctrl.sv
sv/pts_dp.sv
sv/periodic_timer_scheduler.sv
test/tb_periodic_timer_scheduler.sv
